### sv/palette_fade_remap_macros.svh
// assertion macros for the palette fade remapper top level
`ifndef PALETTE_FADE_REMAP_MACROS_SVH
`define PALETTE_FADE_REMAP_MACROS_SVH

// property checked on every clock edge outside reset
`define PFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// condition in one cycle implies consequence in the next
`define PFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pfr_pkg.sv
// package for the palette fade remapper: constants, register map and arithmetic helpers
`default_nettype none

package pfr_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEF = 256;
  localparam int unsigned COLOR_W             = 24;
  localparam int unsigned APB_ADDR_W          = 3;
  localparam int unsigned APB_DATA_W          = 32;
  localparam int unsigned DIST_W              = 16;
  localparam int unsigned SQ_W                = 15;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [0:0] {
    REG_TARGET_COLOR  = 1'b0,
    REG_FADE_FRACTION = 1'b1
  } reg_idx_t;

  // move one component toward the target: c - ((c - t) * frac * 2)[15:8], all mod 256
  function automatic logic [7:0] fade_comp(input logic [7:0] c, input logic [7:0] t,
                                           input logic [6:0] frac);
    logic signed [9:0]  diff;
    logic signed [17:0] prod;
    diff = $signed({c[7], c[7], c}) - $signed({2'b00, t});
    prod = diff * $signed({1'b0, frac});
    return c - prod[14:7];
  endfunction

  // square of the component difference wrapped to int8
  function automatic logic [SQ_W-1:0] sq_wrap(input logic [7:0] s, input logic [7:0] i);
    logic [7:0]         d;
    logic signed [15:0] sp;
    d  = s - i;
    sp = $signed(d) * $signed(d);
    return sp[SQ_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/pfr_ram.sv
// generic single-clock ram, one write port and one read port with registered read data
`default_nettype none

module pfr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### sv/palette_fade_remap.sv
// palette fade remapper: block top level
// A palette of RGB entries is loaded item by item into an on-chip ram over the
// input channel (kind 0). A query item (kind 1) names an entry; the block fades
// that colour toward the colour of entry target_color by fade_fraction and
// returns on the output channel the nearest other entry (1 .. entries-1).
// Entry 0, or an index beyond the palette, maps to 0 without a scan.
// target_color and fade_fraction sit on the APB port at byte addresses 0 and 4.
// A load within the palette is written when it is taken. A query reads the target and
// the queried entry, then makes one ram read per cycle over up to
// PALETTE_ENTRIES-1 candidates through the read and square stages, and then
// posts the result; the single ram read port bounds the scan.
// An exact colour match ends the scan early.
// The next item is taken while a result still waits in the output register;
// a finished query waits while the receiver stalls a pending result, and
// in_stall stays high meanwhile.
// Reset empties the output register and returns to idle; both registers
// clear to zero. Palette entries hold no value until loaded.
`default_nettype none
`include "palette_fade_remap_macros.svh"

module palette_fade_remap
  import pfr_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic [7:0]            entry_index,
  input  logic [7:0]            red_value,
  input  logic [7:0]            green_value,
  input  logic [7:0]            blue_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            queried_index,
  output logic [7:0]            mapped_index
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(PALETTE_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TGT,
    ST_FADE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [7:0] target_color;
  logic [7:0] fade_fraction;
  reg_idx_t   cfg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_color  <= '0;
      fade_fraction <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TARGET_COLOR:  target_color  <= pwdata[7:0];
        REG_FADE_FRACTION: fade_fraction <= pwdata[7:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TARGET_COLOR:  prdata = {24'd0, target_color};
      REG_FADE_FRACTION: prdata = {24'd0, fade_fraction};
      default:           prdata = '0;
    endcase
  end

  // palette ram
  logic                ram_wr_en;
  logic                ram_rd_en;
  logic [AW-1:0]       ram_rd_addr;
  logic [COLOR_W-1:0]  ram_rd_data;

  logic                in_acc;
  logic                idx_ok;
  logic                tgt_ok;

  // scan registers
  logic [AW-1:0]       q_idx;
  logic [7:0]          q_echo;
  logic [COLOR_W-1:0]  tgt_color;
  logic [COLOR_W-1:0]  ideal;
  logic [AW-1:0]       scan_idx;
  logic [DIST_W-1:0]   best;
  logic [7:0]          match;

  // read stage tags, aligned with ram read data
  logic                rd_valid;
  logic                rd_skip;
  logic                rd_last;
  logic [AW-1:0]       rd_idx;
  // square stage
  logic                sq_valid;
  logic                sq_skip;
  logic                sq_last;
  logic [AW-1:0]       sq_idx;
  logic [SQ_W-1:0]     sq_r;
  logic [SQ_W-1:0]     sq_g;
  logic [SQ_W-1:0]     sq_b;

  logic [DIST_W-1:0]   sq_sum;
  logic                eval;
  logic                scan_done;
  logic                out_free;

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign idx_ok    = (32'(entry_index) < PALETTE_ENTRIES);
  assign tgt_ok    = (32'(target_color) < PALETTE_ENTRIES);
  assign ram_wr_en = in_acc && (kind == KIND_LOAD) && idx_ok;

  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = target_color[AW-1:0];
    unique case (state)
      ST_IDLE: begin
        ram_rd_en   = in_acc && (kind == KIND_QUERY);
        ram_rd_addr = target_color[AW-1:0];
      end
      ST_TGT: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = q_idx;
      end
      ST_SCAN: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = scan_idx;
      end
      default: ;
    endcase
  end

  pfr_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(entry_index[AW-1:0]),
    .wr_data({red_value, green_value, blue_value}),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  assign sq_sum    = {1'b0, sq_r} + {1'b0, sq_g} + {1'b0, sq_b};
  assign eval      = sq_valid && !sq_skip;
  assign scan_done = sq_valid && (sq_last || (eval && (sq_sum == '0)));
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      rd_valid  <= 1'b0;
      sq_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // square stage takes the ram data of the read stage
      sq_valid <= rd_valid;
      sq_skip  <= rd_skip;
      sq_last  <= rd_last;
      sq_idx   <= rd_idx;
      sq_r     <= sq_wrap(ram_rd_data[23:16], ideal[23:16]);
      sq_g     <= sq_wrap(ram_rd_data[15:8],  ideal[15:8]);
      sq_b     <= sq_wrap(ram_rd_data[7:0],   ideal[7:0]);
      rd_valid <= 1'b0;

      // compare stage: ties go to the later entry
      if (eval && (sq_sum <= best)) begin
        best  <= sq_sum;
        match <= 8'(sq_idx);
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc && (kind == KIND_QUERY)) begin
            q_echo <= entry_index;
            q_idx  <= entry_index[AW-1:0];
            if (idx_ok && (entry_index != '0)) begin
              state <= ST_TGT;
            end else begin
              match <= '0;
              state <= ST_DONE;
            end
          end
        end
        ST_TGT: begin
          tgt_color <= tgt_ok ? ram_rd_data : '0;
          state     <= ST_FADE;
        end
        ST_FADE: begin
          ideal    <= {fade_comp(ram_rd_data[23:16], tgt_color[23:16], fade_fraction[7:1]),
                       fade_comp(ram_rd_data[15:8],  tgt_color[15:8],  fade_fraction[7:1]),
                       fade_comp(ram_rd_data[7:0],   tgt_color[7:0],   fade_fraction[7:1])};
          best     <= '1;
          match    <= target_color;
          scan_idx <= AW'(1);
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          rd_valid <= 1'b1;
          rd_skip  <= (scan_idx == q_idx);
          rd_last  <= (scan_idx == LAST_ENTRY);
          rd_idx   <= scan_idx;
          if (scan_idx == LAST_ENTRY) begin
            state <= ST_DRAIN;
          end else begin
            scan_idx <= scan_idx + AW'(1);
          end
        end
        ST_DRAIN: ;
        ST_DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            queried_index <= q_echo;
            mapped_index  <= match;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // exact match or last candidate: drop reads still in flight
      if (scan_done) begin
        rd_valid <= 1'b0;
        sq_valid <= 1'b0;
        state    <= ST_DONE;
      end
    end
  end

  `PFR_ASSERT(a_zero_entry,
    (out_valid && queried_index == '0) |-> (mapped_index == '0),
    "entry zero must map to zero")
  `PFR_ASSERT(a_not_self,
    (out_valid && queried_index != '0 && (32'(queried_index) < PALETTE_ENTRIES))
      |-> (mapped_index != queried_index),
    "query mapped to itself")
  `PFR_ASSERT(a_pipe_in_scan,
    (rd_valid || sq_valid) |-> (state == ST_SCAN || state == ST_DRAIN),
    "scan pipeline busy outside scan")
  `PFR_ASSERT_NEXT(a_done_posts,
    state == ST_DONE && !(out_valid && out_stall), out_valid && state == ST_IDLE,
    "finished query not posted")

endmodule

`default_nettype wire

### bench/tb.sv
// testbench for palette_fade_remap: palette loads and fade queries checked against a local predictor
`timescale 1ns / 100ps

module tb;
  import pfr_pkg::*;

  localparam int ENTRIES = PALETTE_ENTRIES_DEF;
  localparam int SETTLE = ENTRIES + 32;
  localparam int LONG_HOLD = 1500;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 220;
  localparam int PHASES = 6;
  localparam int NO_CHECK = -1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] idx;
    rgb_t       rgb;
  } palette_op_t;

  typedef struct packed {
    logic [7:0] queried;
    logic [7:0] mapped;
  } remap_t;

  typedef struct {
    palette_op_t op;
    int          want;
  } table_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  kind = KIND_LOAD;
  logic [7:0]            entry_index = '0;
  logic [7:0]            red_value = '0;
  logic [7:0]            green_value = '0;
  logic [7:0]            blue_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            queried_index;
  logic [7:0]            mapped_index;

  // predictor state
  rgb_t       palette_copy [ENTRIES];
  logic [7:0] target_reg = '0;
  logic [7:0] fraction_reg = '0;

  remap_t     pending_remaps [$];
  table_row_t directed_rows [$];
  logic [7:0] coarse_vals [5] = '{8'h00, 8'h40, 8'h7F, 8'h80, 8'hFF};

  int  errors = 0;
  int  loads_sent = 0;
  int  queries_sent = 0;
  int  remaps_checked = 0;
  bit  idle_on = 1'b1;
  bit  long_hold_req = 1'b0;

  wire item_taken = in_valid & ~in_stall;
  wire result_taken = out_valid & ~out_stall;

  palette_fade_remap uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .entry_index  (entry_index),
    .red_value    (red_value),
    .green_value  (green_value),
    .blue_value   (blue_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .queried_index(queried_index),
    .mapped_index (mapped_index)
  );

  always #2 clk = ~clk;

  // component as int8 moved toward the target by half/128, product kept to 16 bits
  function automatic logic [7:0] fade_toward(logic [7:0] c, logic [7:0] t, int half);
    byte         cs;
    int          prod;
    logic [15:0] p16;
    byte         shifted;
    cs = c;
    prod = (int'(cs) - int'(t)) * half * 2;
    p16 = prod[15:0];
    shifted = p16[15:8];
    return 8'(int'(cs) - int'(shifted));
  endfunction

  function automatic logic [7:0] nearest_faded_entry(logic [7:0] q);
    rgb_t       src;
    rgb_t       tgt;
    rgb_t       ideal;
    rgb_t       cand;
    int         half;
    int         score;
    longint     best;
    logic [7:0] match;
    byte        diff;
    if (q == 0 || int'(q) >= ENTRIES) return 8'd0;
    tgt = (int'(target_reg) < ENTRIES) ? palette_copy[target_reg] : '0;
    src = palette_copy[q];
    half = int'(fraction_reg >> 1);
    ideal.r = fade_toward(src.r, tgt.r, half);
    ideal.g = fade_toward(src.g, tgt.g, half);
    ideal.b = fade_toward(src.b, tgt.b, half);
    best = 64'hFFFF_FFFF;
    match = target_reg;
    for (int j = 1; j < ENTRIES; j++) begin
      if (j == int'(q)) continue;
      cand = palette_copy[j];
      diff = cand.r - ideal.r;
      score = int'(diff) * int'(diff);
      diff = cand.g - ideal.g;
      score += int'(diff) * int'(diff);
      diff = cand.b - ideal.b;
      score += int'(diff) * int'(diff);
      // ties go to the later entry, an exact match ends the scan
      if (score <= best) begin
        best = score;
        match = 8'(j);
      end
      if (score == 0) break;
    end
    return match;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic palette_op_t random_op();
    palette_op_t op;
    rgb_t        src;
    int          style;
    op.kind = ($urandom_range(99) < 40) ? KIND_QUERY : KIND_LOAD;
    op.idx = 8'($urandom_range(255));
    op.rgb = 24'($urandom);
    if (op.kind == KIND_QUERY) begin
      style = $urandom_range(19);
      if (style == 0) begin
        op.idx = 8'd0;
      end else if (style == 1) begin
        op.idx = target_reg;
      end else if (style == 2) begin
        op.idx = 8'hFF;
      end
    end else begin
      style = $urandom_range(3);
      if (style == 1) begin
        op.rgb = {coarse_vals[$urandom_range(4)], coarse_vals[$urandom_range(4)],
                  coarse_vals[$urandom_range(4)]};
      end else if (style == 2) begin
        // duplicates and near duplicates give exact matches and ties
        src = palette_copy[$urandom_range(ENTRIES - 1)];
        op.rgb = src;
        if ($urandom_range(1) == 1) op.rgb.b = src.b + 8'd1;
      end
    end
    return op;
  endfunction

  task automatic add_row(logic k, logic [7:0] i, logic [23:0] c, int want);
    table_row_t row;
    row.op.kind = k;
    row.op.idx = i;
    row.op.rgb = c;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic send_op(palette_op_t op, int fixed, int gap);
    remap_t exp_remap;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    kind <= op.kind;
    entry_index <= op.idx;
    red_value <= op.rgb.r;
    green_value <= op.rgb.g;
    blue_value <= op.rgb.b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (op.kind == KIND_LOAD) begin
      palette_copy[op.idx] = op.rgb;
      loads_sent++;
    end else begin
      exp_remap.queried = op.idx;
      exp_remap.mapped = (fixed >= 0) ? 8'(fixed) : nearest_faded_entry(op.idx);
      pending_remaps.push_back(exp_remap);
      queries_sent++;
    end
  endtask

  task automatic hold_input_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_remaps.size() != 0) @(posedge clk);
  endtask

  // write then read back one register
  task automatic write_register(reg_idx_t r, logic [7:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= {24'h0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (r == REG_TARGET_COLOR) target_reg = v;
    else fraction_reg = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[7:0] !== v) begin
      errors++;
      $display("%0t: register %s read back expected %0d got %0d", $time, r.name(), v,
               prdata[7:0]);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(logic [7:0] tgt, logic [7:0] frac);
    hold_input_until_drained();
    // loads give no result, so let any last item finish before touching registers
    repeat (SETTLE) @(posedge clk);
    write_register(REG_TARGET_COLOR, tgt);
    write_register(REG_FADE_FRACTION, frac);
  endtask

  initial begin : stimulus
    logic [7:0] tgt;
    logic [7:0] frac;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every entry gets a distinct colour before the first query
    for (int i = 0; i < ENTRIES; i++) begin
      send_op({KIND_LOAD, 8'(i), 8'(i), 8'(i * 3 + 1), ~8'(i)}, NO_CHECK, pick_gap());
    end

    add_row(KIND_QUERY, 8'd0, 24'hFFFFFF, 0);
    add_row(KIND_LOAD, 8'd5, 24'hAA55C3, NO_CHECK);
    add_row(KIND_LOAD, 8'd9, 24'hAA55C3, NO_CHECK);
    add_row(KIND_QUERY, 8'd5, 24'h000000, 9);
    add_row(KIND_QUERY, 8'd9, 24'h000000, 5);
    add_row(KIND_LOAD, 8'd1, 24'h000000, NO_CHECK);
    add_row(KIND_LOAD, 8'd255, 24'hFFFFFF, NO_CHECK);
    add_row(KIND_QUERY, 8'd1, 24'hFFFFFF, NO_CHECK);
    add_row(KIND_QUERY, 8'd255, 24'h000000, NO_CHECK);
    add_row(KIND_LOAD, 8'd200, 24'h808080, NO_CHECK);
    add_row(KIND_LOAD, 8'd201, 24'h7F7F7F, NO_CHECK);
    add_row(KIND_QUERY, 8'd200, 24'h000000, NO_CHECK);
    add_row(KIND_QUERY, 8'd201, 24'h000000, NO_CHECK);
    add_row(KIND_LOAD, 8'd20, 24'h101010, NO_CHECK);
    add_row(KIND_LOAD, 8'd30, 24'h101010, NO_CHECK);
    add_row(KIND_QUERY, 8'd20, 24'h000000, 30);
    add_row(KIND_LOAD, 8'd40, 24'h101011, NO_CHECK);
    add_row(KIND_QUERY, 8'd40, 24'h000000, NO_CHECK);
    add_row(KIND_QUERY, 8'd3, 24'hFFFFFF, NO_CHECK);
    add_row(KIND_QUERY, 8'd128, 24'h5A5A5A, NO_CHECK);
    foreach (directed_rows[n]) begin
      send_op(directed_rows[n].op, directed_rows[n].want, pick_gap());
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          tgt = 8'hFF;
          frac = 8'hFF;
        end
        1: begin
          tgt = 8'h00;
          frac = 8'h01;
        end
        2: begin
          tgt = 8'h80;
          frac = 8'hFE;
        end
        3: begin
          tgt = 8'($urandom_range(255));
          frac = 8'h80;
        end
        4: begin
          tgt = 8'($urandom_range(255));
          frac = 8'($urandom_range(255));
        end
        default: begin
          tgt = 8'($urandom_range(255));
          frac = 8'h00;
        end
      endcase
      apply_setting(tgt, frac);
      idle_on = (ph % 3 != 1);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if (ph == 2 && n == 30) long_hold_req = 1'b1;
        if ($urandom_range(99) == 0) hold_input_until_drained();
        send_op(random_op(), NO_CHECK, idle_on ? pick_gap() : 0);
      end
    end

    hold_input_until_drained();
    repeat (SETTLE) @(posedge clk);
    $display("run covered %0d palette loads and %0d queries over %0d fade settings,",
             loads_sent, queries_sent, PHASES + 1);
    $display("with %0d remapped indexes compared and %0d mismatches", remaps_checked, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : result_stall_driver
    int run;
    bit hold_val;
    run = 0;
    hold_val = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        // block fills up behind a held result while items keep coming
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
        run = 0;
      end else begin
        if (run == 0) begin
          hold_val = idle_on && ($urandom_range(2) == 0);
          run = hold_val ? pick_gap() + 1 : $urandom_range(1, 8);
        end
        out_stall <= hold_val;
        run--;
      end
    end
  end

  always @(posedge clk) begin : remap_check
    remap_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_remaps.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, queried_index %0d mapped_index %0d", $time,
                 queried_index, mapped_index);
      end else begin
        want = pending_remaps.pop_front();
        remaps_checked++;
        if (queried_index !== want.queried) begin
          errors++;
          $display("%0t: queried_index expected %0d got %0d", $time, want.queried,
                   queried_index);
        end
        if (mapped_index !== want.mapped) begin
          errors++;
          $display("%0t: mapped_index for entry %0d expected %0d got %0d", $time,
                   want.queried, want.mapped, mapped_index);
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (item_taken === 1'b1 || result_taken === 1'b1) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no item or result moved for %0d cycles, %0d results outstanding", $time,
             WATCHDOG_LIMIT, pending_remaps.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/pfr_pkg.sv
sv/pfr_ram.sv
sv/palette_fade_remap.sv
bench/tb.sv
